### hw/rtl/sdq_pkg.sv
// Shared types for the signed divider: controller state, cell control and cell status.
// No dependencies; sdq_cell and the top level of the divider import this package.
package sdq_pkg;

   // Controller states of the divider sequencer.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_FIX
   } state_type;

   // Control broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic load;   // take the operand magnitudes and clear the remainder
      logic step;   // perform one shift and trial subtract
      logic take;   // trial subtract did not borrow, keep the difference
   } sdq_ctrl_type;

   // Status handed by a cell to its upper neighbor and to the sequencer.
   typedef struct packed {
      logic rem;     // partial remainder bit held by the cell
      logic quo;     // dividend / quotient bit held by the cell
      logic borrow;  // borrow out of the trial subtraction at this bit
   } sdq_cell_out_type;

endpackage

### hw/rtl/sdq_cell.sv
// One bit slice of the restoring divider row: remainder, quotient and divisor bits.
// Depends on sdq_pkg for the control and status structs.
module sdq_cell (
   input  logic                      clock,
   input  sdq_pkg::sdq_ctrl_type     ctrl,
   input  logic                      load_quo,
   input  logic                      load_div,
   input  logic                      rem_in,
   input  logic                      quo_in,
   input  logic                      borrow_in,
   output sdq_pkg::sdq_cell_out_type cell_out
);
   import sdq_pkg::*;

   logic rem_ff;
   logic quo_ff;
   logic div_ff;
   logic diff;

   // One bit of the trial subtraction on the shifted remainder.
   always_comb begin
      diff              = rem_in ^ div_ff ^ borrow_in;
      cell_out.borrow   = (~rem_in & div_ff) | (~(rem_in ^ div_ff) & borrow_in);
      cell_out.rem      = rem_ff;
      cell_out.quo      = quo_ff;
   end

   // Load the operands, or shift in from the lower neighbor and keep the
   // difference when the whole subtraction did not borrow.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rem_ff <= 1'b0;
         quo_ff <= load_quo;
         div_ff <= load_div;
      end else if (ctrl.step) begin
         rem_ff <= ctrl.take ? diff : rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

### hw/rtl/signed_divider_quotient_remainder.sv
// Signed truncating divider: sequencer, sign handling and a row of bit-slice cells.
// A request word runs through the states ST_PREP (operand magnitudes into the cell row),
// ST_RUN (one quotient bit per cycle in the cell row) and ST_FIX (sign fixup into the
// response word register, which raises response valid). A new request word is taken only
// once the sequencer is back in ST_IDLE; a stalled response holds the fixup.
// Synchronous active-high reset clears the sequencer and the response valid.
module signed_divider_quotient_remainder #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_dividend,
   input  logic signed [DATA_WIDTH-1:0] req_divisor_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_quotient,
   output logic signed [DATA_WIDTH-1:0] rsp_remainder,
   output logic                         rsp_divide_by_zero,
   output logic                         rsp_quotient_overflow
);
   import sdq_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0]  a_ff, b_ff;
   logic                   neg_a_ff, neg_q_ff, zero_ff, ovf_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]  quo_ff, rem_ff;
   logic                   dbz_ff, qov_ff;

   logic [DATA_WIDTH-1:0]  mag_a, mag_b;
   logic [DATA_WIDTH-1:0]  q_vec, r_vec;
   logic                   req_accept, rsp_accept, out_load;
   sdq_ctrl_type           ctrl;
   sdq_cell_out_type       cell_out [DATA_WIDTH];

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   // Operand magnitudes from the captured request word.
   always_comb begin
      mag_a = a_ff[DATA_WIDTH-1] ? (~a_ff + 1'b1) : a_ff;
      mag_b = b_ff[DATA_WIDTH-1] ? (~b_ff + 1'b1) : b_ff;
   end

   // Sequencer: next state, cell control and output register load.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ctrl.load    = 1'b0;
      ctrl.step    = 1'b0;
      ctrl.take    = ~cell_out[DATA_WIDTH-1].borrow;
      out_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ctrl.load = 1'b1;
            cnt_in    = '0;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            ctrl.step = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_WIDTH - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = out_load ? 1'b1 : (rsp_accept ? 1'b0 : rsp_valid_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured operands and the sign and special-case flags.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_ff <= req_dividend;
         b_ff <= req_divisor_value;
      end
      if (ctrl.load) begin
         neg_a_ff <= a_ff[DATA_WIDTH-1];
         neg_q_ff <= a_ff[DATA_WIDTH-1] ^ b_ff[DATA_WIDTH-1];
         zero_ff  <= (b_ff == '0);
         ovf_ff   <= (a_ff == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (b_ff == '1);
      end
   end

   // Row of bit-slice cells; the remainder shifts up through the row and the
   // top quotient bit feeds the bottom of the remainder.
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      logic rem_in_w, quo_in_w, borrow_in_w;
      if (i == 0) begin : g_low
         assign rem_in_w    = cell_out[DATA_WIDTH-1].quo;
         assign quo_in_w    = ctrl.take;
         assign borrow_in_w = 1'b0;
      end else begin : g_up
         assign rem_in_w    = cell_out[i-1].rem;
         assign quo_in_w    = cell_out[i-1].quo;
         assign borrow_in_w = cell_out[i-1].borrow;
      end
      sdq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_quo  (mag_a[i]),
         .load_div  (mag_b[i]),
         .rem_in    (rem_in_w),
         .quo_in    (quo_in_w),
         .borrow_in (borrow_in_w),
         .cell_out  (cell_out[i])
      );
      assign q_vec[i] = cell_out[i].quo;
      assign r_vec[i] = cell_out[i].rem;
   end

   // Sign fixup into the response word register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         if (zero_ff) begin
            quo_ff <= '0;
            rem_ff <= '0;
         end else begin
            quo_ff <= neg_q_ff ? (~q_vec + 1'b1) : q_vec;
            rem_ff <= neg_a_ff ? (~r_vec + 1'b1) : r_vec;
         end
         dbz_ff <= zero_ff;
         qov_ff <= ovf_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_quotient          = quo_ff;
   assign rsp_remainder         = rem_ff;
   assign rsp_divide_by_zero    = dbz_ff;
   assign rsp_quotient_overflow = qov_ff;

endmodule

### hw/rtl/sdq_checker.sv
// Port-level checks for the signed divider, attached to the top level by bind.
// Depends on the ports of signed_divider_quotient_remainder only.
module sdq_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [DATA_WIDTH-1:0] rsp_quotient,
   input logic signed [DATA_WIDTH-1:0] rsp_remainder,
   input logic                         rsp_divide_by_zero,
   input logic                         rsp_quotient_overflow
);

   // A stalled response word stays valid and holds its quotient and remainder.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quotient) && $stable(rsp_remainder))
      else $error("stalled response word changed");

   // A zero divisor gives zero quotient and remainder and no overflow.
   a_dbz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |->
         rsp_quotient == '0 && rsp_remainder == '0 && !rsp_quotient_overflow)
      else $error("divide by zero response is not clean");

   // Overflow only for most negative over minus one: wrapped quotient, zero remainder.
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quotient_overflow |->
         rsp_remainder == '0 && !rsp_divide_by_zero &&
         rsp_quotient == {1'b1, {(DATA_WIDTH-1){1'b0}}})
      else $error("overflow response is inconsistent");

   // No response word in the first cycle after reset is released.
   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // A request accepted just now cannot already be answered in the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response word appeared too early");

endmodule

bind signed_divider_quotient_remainder sdq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sdq_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the signed truncating divider.
// It depends only on the module signed_divider_quotient_remainder. Each word's result is
// predicted here or given in the directed table, and compared field by field in order.
module testbench;

   localparam int WIDTH       = 32;
   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_WORDS = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 5000;

   localparam logic signed [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic signed [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic signed [WIDTH-1:0] MINUS_ONE = '1;

   // One result word as the divider returns it.
   typedef struct {
      logic signed [WIDTH-1:0] quotient;
      logic signed [WIDTH-1:0] remainder;
      logic                    divide_by_zero;
      logic                    quotient_overflow;
   } quotient_word_type;

   // One row of the directed stimulus; typed rows carry their own answer.
   typedef struct {
      logic signed [WIDTH-1:0] dividend;
      logic signed [WIDTH-1:0] divisor_value;
      bit                      typed;
      quotient_word_type       answer;
   } division_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [WIDTH-1:0] req_dividend = '0;
   logic signed [WIDTH-1:0] req_divisor_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [WIDTH-1:0] rsp_quotient;
   logic signed [WIDTH-1:0] rsp_remainder;
   logic                    rsp_divide_by_zero;
   logic                    rsp_quotient_overflow;

   quotient_word_type pending_quotients[$];
   quotient_word_type offered_answer;
   division_row_type  directed_rows[$];
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   bit             timed_out = 1'b0;
   bit             stimulus_done = 1'b0;
   bit             calm = 1'b0;

   signed_divider_quotient_remainder #(
      .DATA_WIDTH(WIDTH)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_dividend         (req_dividend),
      .req_divisor_value    (req_divisor_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_quotient         (rsp_quotient),
      .rsp_remainder        (rsp_remainder),
      .rsp_divide_by_zero   (rsp_divide_by_zero),
      .rsp_quotient_overflow(rsp_quotient_overflow)
   );

   // Free-running clock.
   always #HALF_PERIOD clock = ~clock;

   // Truncating division: divide the magnitudes, then restore the signs.
   function automatic quotient_word_type divide_truncating(input logic [WIDTH-1:0] num,
                                                           input logic [WIDTH-1:0] den);
      quotient_word_type word;
      logic [WIDTH-1:0] mag_num;
      logic [WIDTH-1:0] mag_den;
      logic [WIDTH-1:0] mag_quo;
      logic [WIDTH-1:0] mag_rem;
      word.divide_by_zero    = 1'b0;
      word.quotient_overflow = 1'b0;
      if (den == '0) begin
         word.quotient       = '0;
         word.remainder      = '0;
         word.divide_by_zero = 1'b1;
         return word;
      end
      mag_num = num[WIDTH-1] ? (~num + 1'b1) : num;
      mag_den = den[WIDTH-1] ? (~den + 1'b1) : den;
      mag_quo = mag_num / mag_den;
      mag_rem = mag_num % mag_den;
      word.quotient  = (num[WIDTH-1] ^ den[WIDTH-1]) ? (~mag_quo + 1'b1) : mag_quo;
      word.remainder = num[WIDTH-1] ? (~mag_rem + 1'b1) : mag_rem;
      word.quotient_overflow = (num == MOST_NEG) && (den == MINUS_ONE);
      return word;
   endfunction

   // Idle length: mostly none or short, now and then long; none in calm stretches.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (calm || pick < 50)
         return 0;
      else if (pick < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Operand mix: full-range values, small values, extremes, powers of two and random shorter values.
   function automatic logic signed [WIDTH-1:0] random_operand();
      logic signed [WIDTH-1:0] value;
      value = $urandom;
      case ($urandom_range(0, 7))
         0, 1: value = $urandom;
         2:    value = $signed($urandom_range(0, 20)) - 10;
         3:    value = MOST_NEG;
         4:    value = MOST_POS;
         5:    value = MINUS_ONE;
         6: begin
            value = 1 << $urandom_range(0, WIDTH - 1);
            if ($urandom_range(0, 1)) value = -value;
         end
         default: begin
            value = $urandom >> $urandom_range(1, WIDTH - 1);
            if ($urandom_range(0, 1)) value = -value;
         end
      endcase
      return value;
   endfunction

   function automatic quotient_word_type typed_word(input logic signed [WIDTH-1:0] quo,
                                                    input logic signed [WIDTH-1:0] rem,
                                                    input logic dbz,
                                                    input logic ovf);
      quotient_word_type word;
      word.quotient          = quo;
      word.remainder         = rem;
      word.divide_by_zero    = dbz;
      word.quotient_overflow = ovf;
      return word;
   endfunction

   task automatic add_row(input logic signed [WIDTH-1:0] num,
                          input logic signed [WIDTH-1:0] den,
                          input bit typed,
                          input quotient_word_type answer);
      division_row_type row;
      row.dividend      = num;
      row.divisor_value = den;
      row.typed         = typed;
      row.answer        = typed ? answer : divide_truncating(num, den);
      directed_rows.push_back(row);
   endtask

   // Offer one request word after a random idle gap and hold it until accepted.
   task automatic send_word(input logic signed [WIDTH-1:0] num,
                            input logic signed [WIDTH-1:0] den,
                            input quotient_word_type answer);
      int gap;
      gap = idle_length();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      offered_answer = answer;
      req_valid         <= 1'b1;
      req_dividend      <= num;
      req_divisor_value <= den;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Response side stalls in random bursts.
   initial begin : response_stall
      int hold;
      @(negedge clock);
      forever begin
         hold = idle_length();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   end

   // Check result words in order, record accepted request words, watch for hangs.
   always @(posedge clock) begin : scoreboard
      quotient_word_type want;
      bit                moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_quotients.size() == 0) begin
               $error("result word with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_quotients.pop_front();
               if (rsp_quotient !== want.quotient) begin
                  $error("quotient: expected %0d, actual %0d", want.quotient, rsp_quotient);
                  mismatch_count++;
               end
               if (rsp_remainder !== want.remainder) begin
                  $error("remainder: expected %0d, actual %0d",
                         want.remainder, rsp_remainder);
                  mismatch_count++;
               end
               if (rsp_divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero: expected %0b, actual %0b",
                         want.divide_by_zero, rsp_divide_by_zero);
                  mismatch_count++;
               end
               if (rsp_quotient_overflow !== want.quotient_overflow) begin
                  $error("quotient_overflow: expected %0b, actual %0b",
                         want.quotient_overflow, rsp_quotient_overflow);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            pending_quotients.push_back(offered_answer);
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      // A run with no word moving for too long is stuck; end it here.
      if (idle_cycles >= STALL_LIMIT) begin
         timed_out = 1'b1;
         $error("no word accepted for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // Reset, directed table, random words, drain, verdict.
   initial begin : main_sequence
      logic signed [WIDTH-1:0] num;
      logic signed [WIDTH-1:0] den;
      quotient_word_type       unused;

      unused = typed_word('0, '0, 1'b0, 1'b0);
      // Zero divisor with extreme dividends.
      add_row('0,        '0, 1'b1, typed_word('0, '0, 1'b1, 1'b0));
      add_row(MOST_POS,  '0, 1'b1, typed_word('0, '0, 1'b1, 1'b0));
      add_row(MOST_NEG,  '0, 1'b1, typed_word('0, '0, 1'b1, 1'b0));
      add_row(MINUS_ONE, '0, 1'b1, typed_word('0, '0, 1'b1, 1'b0));
      // Most negative over minus one wraps and raises overflow.
      add_row(MOST_NEG, MINUS_ONE, 1'b1, typed_word(MOST_NEG, '0, 1'b0, 1'b1));
      // Extremes of both operands.
      add_row(MOST_POS, 1,         1'b1, typed_word(MOST_POS, '0, 1'b0, 1'b0));
      add_row(MOST_NEG, 1,         1'b1, typed_word(MOST_NEG, '0, 1'b0, 1'b0));
      add_row(MOST_POS, MINUS_ONE, 1'b1, typed_word(-MOST_POS, '0, 1'b0, 1'b0));
      add_row(MOST_NEG, MOST_NEG,  1'b1, typed_word(1, '0, 1'b0, 1'b0));
      add_row(MOST_POS, MOST_POS,  1'b1, typed_word(1, '0, 1'b0, 1'b0));
      add_row(MOST_POS, MOST_NEG,  1'b1, typed_word('0, MOST_POS, 1'b0, 1'b0));
      add_row(MOST_NEG, MOST_POS,  1'b1, typed_word(MINUS_ONE, MINUS_ONE, 1'b0, 1'b0));
      add_row('0,       MOST_NEG,  1'b1, typed_word('0, '0, 1'b0, 1'b0));
      add_row(1,        MOST_NEG,  1'b1, typed_word('0, 1, 1'b0, 1'b0));
      // Every sign combination, checked against the predictor.
      add_row(7,  2,  1'b0, unused);
      add_row(-7, 2,  1'b0, unused);
      add_row(7,  -2, 1'b0, unused);
      add_row(-7, -2, 1'b0, unused);
      add_row(-6, 3,  1'b0, unused);
      add_row(MINUS_ONE, MOST_POS, 1'b0, unused);
      add_row(100, -7, 1'b0, unused);
      add_row(32'sh5555_5555, 3, 1'b0, unused);
      add_row(32'shAAAA_AAAA, 32'sh0001_0001, 1'b0, unused);
      add_row(MOST_NEG, 2, 1'b0, unused);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].dividend, directed_rows[i].divisor_value,
                   directed_rows[i].answer);

      for (int n = 0; n < RANDOM_WORDS && !timed_out; n++) begin
         // Every fourth stretch of words runs without idling.
         calm = ((n / 250) % 4) == 3;
         num = random_operand();
         den = random_operand();
         send_word(num, den, divide_truncating(num, den));
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;
      stimulus_done = 1'b1;

      while (!timed_out && pending_quotients.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && !timed_out && pending_quotients.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### signed_divider_quotient_remainder.f
hw/rtl/sdq_pkg.sv
hw/rtl/sdq_cell.sv
hw/rtl/signed_divider_quotient_remainder.sv
hw/rtl/sdq_checker.sv
tb/testbench.sv
